### design/hpack_pkg.sv
package hpack_pkg;

  localparam logic [2:0] CMD_INDEXED      = 3'd0;
  localparam logic [2:0] CMD_SIZE_UPDATE  = 3'd1;
  localparam logic [2:0] CMD_LITERAL      = 3'd2;
  localparam logic [2:0] CMD_NAME_INDEX   = 3'd3;
  localparam logic [2:0] CMD_STRING_LEN   = 3'd4;
  localparam logic [2:0] CMD_STRING_BYTE  = 3'd5;

  localparam logic [1:0] KIND_INCREMENTAL = 2'd0;
  localparam logic [1:0] KIND_NO_INDEX    = 2'd1;
  localparam logic [1:0] KIND_NEVER_INDEX = 2'd2;

  localparam logic [7:0] MASK_7BIT        = 8'h7f;
  localparam logic [7:0] MASK_5BIT        = 8'h1f;
  localparam logic [7:0] MASK_4BIT        = 8'h0f;

  localparam logic [7:0] TOP_INDEXED      = 8'h80;
  localparam logic [7:0] TOP_SIZE_UPDATE  = 8'h20;
  localparam logic [7:0] TOP_NONE         = 8'h00;

  localparam logic [7:0] TYPE_INCREMENTAL = 8'h40;
  localparam logic [7:0] TYPE_NO_INDEX    = 8'h00;
  localparam logic [7:0] TYPE_NEVER_INDEX = 8'h10;

  localparam logic [7:0] CONT_BIT         = 8'h80;

  // one classified request: leading octet, and the prefix-integer tail if any
  typedef struct packed {
    logic [7:0]  first_octet;
    logic        more;
    logic [31:0] rem;
  } hpack_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hpack_q_status_t;

endpackage

### design/hpack_front.sv
module hpack_front (
  input  logic [2:0]          cmd,
  input  logic [31:0]         value,
  input  logic [1:0]          literal_kind,
  input  logic [7:0]          data_byte,
  output logic                entry_valid,
  output hpack_pkg::hpack_entry_t entry
);

  logic [7:0] mask;
  logic [7:0] top;
  logic       is_int;
  logic       over;

  always_comb begin
    mask        = hpack_pkg::MASK_7BIT;
    top         = hpack_pkg::TOP_NONE;
    is_int      = 1'b0;
    entry_valid = 1'b1;
    unique case (cmd)
      hpack_pkg::CMD_INDEXED: begin
        mask   = hpack_pkg::MASK_7BIT;
        top    = hpack_pkg::TOP_INDEXED;
        is_int = 1'b1;
      end
      hpack_pkg::CMD_SIZE_UPDATE: begin
        mask   = hpack_pkg::MASK_5BIT;
        top    = hpack_pkg::TOP_SIZE_UPDATE;
        is_int = 1'b1;
      end
      hpack_pkg::CMD_NAME_INDEX: begin
        mask   = hpack_pkg::MASK_4BIT;
        is_int = 1'b1;
      end
      hpack_pkg::CMD_STRING_LEN: begin
        mask   = hpack_pkg::MASK_7BIT;
        is_int = 1'b1;
      end
      hpack_pkg::CMD_LITERAL, hpack_pkg::CMD_STRING_BYTE: begin
      end
      default: entry_valid = 1'b0;
    endcase
  end

  assign over = (value >= {24'd0, mask});

  always_comb begin
    entry.rem  = value - {24'd0, mask};
    entry.more = is_int & over;
    if (is_int) begin
      entry.first_octet = top | (over ? mask : value[7:0]);
    end else if (cmd == hpack_pkg::CMD_LITERAL) begin
      priority if (literal_kind == hpack_pkg::KIND_INCREMENTAL) begin
        entry.first_octet = hpack_pkg::TYPE_INCREMENTAL;
      end else if (literal_kind == hpack_pkg::KIND_NEVER_INDEX) begin
        entry.first_octet = hpack_pkg::TYPE_NEVER_INDEX;
      end else begin
        // no-index kind and the unused code both give the plain type octet
        entry.first_octet = hpack_pkg::TYPE_NO_INDEX;
      end
    end else begin
      entry.first_octet = data_byte;
    end
  end

endmodule

### design/hpack_queue.sv
module hpack_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  hpack_pkg::hpack_entry_t push_data,
  input  logic                    pop,
  output hpack_pkg::hpack_entry_t pop_data,
  output hpack_pkg::hpack_q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hpack_pkg::hpack_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FULL_CNT);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/hpack_back.sv
module hpack_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_avail,
  input  hpack_pkg::hpack_entry_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_last
);

  logic        active_r, active_nxt;
  logic        tail_r, tail_nxt;
  logic        more_r, more_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        rem_small;
  logic        done;

  assign rem_small = (rem_r[31:7] == '0);

  always_comb begin
    if (tail_r) begin
      out_byte = rem_small ? rem_r[7:0] : (hpack_pkg::CONT_BIT | {1'b0, rem_r[6:0]});
      out_last = rem_small;
    end else begin
      out_byte = first_r;
      out_last = ~more_r;
    end
  end

  assign out_valid = active_r;
  assign done      = active_r & out_last;
  assign q_pop     = (~active_r | done) & q_avail;

  always_comb begin
    active_nxt = active_r;
    tail_nxt   = tail_r;
    more_nxt   = more_r;
    first_nxt  = first_r;
    rem_nxt    = rem_r;
    if (!active_r || done) begin
      active_nxt = q_avail;
      tail_nxt   = 1'b0;
      more_nxt   = q_data.more;
      first_nxt  = q_data.first_octet;
      rem_nxt    = q_data.rem;
    end else if (!tail_r) begin
      tail_nxt = 1'b1;
    end else begin
      rem_nxt = {7'd0, rem_r[31:7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tail_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      tail_r   <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    more_r  <= more_nxt;
    first_r <= first_nxt;
    rem_r   <= rem_nxt;
  end

endmodule

### design/hpack_header_field_encoder_core.sv
// HPACK header field encoder.
// Input: one command per request, taken at a clock edge with start high and
// busy low (in_cmd, in_value, in_literal_kind, in_data_byte). Commands are
// indexed field, table size update, literal start, name index, string
// length and string byte; codes 6 and 7 are dropped without output.
// Output: one octet per cycle on out_byte with out_valid high for that cycle;
// out_last marks the final octet of a request. The receiver cannot stall,
// so octets are never held back.
// A front stage classifies the request and works out the leading octet and
// the prefix-integer remainder; a queue of QUEUE_DEPTH entries holds
// classified requests; the back end walks the 7-bit groups.
// A request accepted into an empty block passes the queue and is loaded into
// the back-end registers before its first octet appears. A literal or
// string-byte request gives one octet, an integer request 1 to 6 octets.
// busy is high while the queue is full.
// Reset (rst_n low, synchronous) empties the queue and idles the back end.
module hpack_header_field_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_literal_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  hpack_pkg::hpack_entry_t    fe_entry;
  hpack_pkg::hpack_entry_t    q_head;
  hpack_pkg::hpack_q_status_t q_status;
  logic                       fe_valid;
  logic                       q_pop;
  logic                       accept;

  assign busy   = q_status.full;
  assign accept = start & ~busy;

  hpack_front u_front (
    .cmd          (in_cmd),
    .value        (in_value),
    .literal_kind (in_literal_kind),
    .data_byte    (in_data_byte),
    .entry_valid  (fe_valid),
    .entry        (fe_entry)
  );

  hpack_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept & fe_valid),
    .push_data (fe_entry),
    .pop       (q_pop),
    .pop_data  (q_head),
    .status    (q_status)
  );

  hpack_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (~q_status.empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // octets of one request come out back to back
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a request's octets");

  // a queued request starts right after the previous one ends
  a_next_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !q_status.empty |=> out_valid)
    else $error("back end idled with a queued request");

  // an accepted request into an idle, empty block reaches the output after the queue and the back-end registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fe_valid && q_status.empty && !out_valid |-> ##2 out_valid)
    else $error("first octet late");

endmodule
